// ===== src/lfjc_pkg.sv =====
// shared types, codes and helpers for the line follower junction controller
package lfjc_pkg;

    // modes
    localparam logic [1:0] MODE_FOLLOW    = 2'd0;
    localparam logic [1:0] MODE_POTENTIAL = 2'd1;
    localparam logic [1:0] MODE_CONFIRM   = 2'd2;
    localparam logic [1:0] MODE_LOST      = 2'd3;

    // motion commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_FORWARD = 3'd1;
    localparam logic [2:0] CMD_LEFT    = 3'd2;
    localparam logic [2:0] CMD_RIGHT   = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;

    // junction kinds
    localparam logic [2:0] JK_NONE      = 3'd0;
    localparam logic [2:0] JK_LEFT      = 3'd1;
    localparam logic [2:0] JK_RIGHT     = 3'd2;
    localparam logic [2:0] JK_T_LEFT    = 3'd3;
    localparam logic [2:0] JK_T_RIGHT   = 3'd4;
    localparam logic [2:0] JK_T_FORWARD = 3'd5;

    // register indexes
    localparam logic [1:0] REG_BASE_SPEED   = 2'd0;
    localparam logic [1:0] REG_LOST_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_JUNC_DELAY   = 2'd2;
    localparam logic [1:0] REG_SETTLE       = 2'd3;

    // register reset values
    localparam logic [7:0]  BASE_SPEED_RST   = 8'd100;
    localparam logic [31:0] LOST_TIMEOUT_RST = 32'd2000;
    localparam logic [31:0] JUNC_DELAY_RST   = 32'd1000;
    localparam logic [15:0] SETTLE_RST       = 16'd200;

    // spin speeds by turn magnitude
    localparam logic [7:0] SPIN_SPEED_1 = 8'd25;
    localparam logic [7:0] SPIN_SPEED_2 = 8'd50;
    localparam logic [7:0] SPIN_SPEED_3 = 8'd75;

    // sensor groups
    localparam logic [7:0] MASK_LEFT   = 8'h03;
    localparam logic [7:0] MASK_CENTER = 8'h18;
    localparam logic [7:0] MASK_RIGHT  = 8'hC0;
    localparam logic [7:0] MASK_ALL    = 8'hFF;

    typedef struct packed {
        logic [7:0]  black_mask;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0] motion_cmd;
        logic [7:0] drive_speed;
        logic [2:0] junction_kind;
        logic       at_junction;
        logic [1:0] mode_now;
    } result_t;

    typedef struct packed {
        logic [7:0]  base_speed;
        logic [31:0] lost_timeout_ms;
        logic [31:0] junction_delay_ms;
        logic [15:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       mode_start_ms;
        logic [31:0]       lost_since_ms;
        logic              lost_since_valid;
        logic signed [2:0] turn_level;
        logic [2:0]        junction_store;
        logic [2:0]        saved_sides;
    } state_t;

    // number of black sensors
    function automatic logic [3:0] count_black(input logic [7:0] m);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, m[i]};
        end
        return c;
    endfunction

    // left, center, right occupancy
    function automatic logic [2:0] sides_of(input logic [7:0] m);
        return {|(m & MASK_RIGHT), |(m & MASK_CENTER), |(m & MASK_LEFT)};
    endfunction

endpackage

// ===== src/lfjc_cfg.sv =====
// configuration register file
module lfjc_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    output lfjc_pkg::cfg_t     cfg
);
    import lfjc_pkg::*;

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed        <= BASE_SPEED_RST;
            cfg_reg.lost_timeout_ms   <= LOST_TIMEOUT_RST;
            cfg_reg.junction_delay_ms <= JUNC_DELAY_RST;
            cfg_reg.settle_ms         <= SETTLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_SPEED:   cfg_reg.base_speed        <= cfg_wdata[7:0];
                REG_LOST_TIMEOUT: cfg_reg.lost_timeout_ms   <= cfg_wdata;
                REG_JUNC_DELAY:   cfg_reg.junction_delay_ms <= cfg_wdata;
                REG_SETTLE:       cfg_reg.settle_ms         <= cfg_wdata[15:0];
                default:          cfg_reg.base_speed        <= cfg_reg.base_speed;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lfjc_step.sv =====
// one update: next state and result from the current state and one sensor beat
module lfjc_step (
    input  lfjc_pkg::state_t  state,
    input  lfjc_pkg::cfg_t    cfg,
    input  lfjc_pkg::item_t   item,
    output lfjc_pkg::state_t  state_next,
    output lfjc_pkg::result_t res
);
    import lfjc_pkg::*;

    logic [7:0]        m;
    logic [31:0]       since_mode;
    logic [31:0]       since_lost;
    logic [3:0]        nblack;
    logic signed [2:0] follow_level;
    logic signed [2:0] steer_level;
    logic [2:0]        steer_cmd;
    logic [7:0]        steer_speed;
    logic [2:0]        kind;
    logic              sl;
    logic              sc;
    logic              sr;
    logic [2:0]        cmd;
    logic [7:0]        spd;

    assign m          = item.black_mask;
    assign since_mode = item.now_ms - state.mode_start_ms;
    assign since_lost = item.now_ms - state.lost_since_ms;
    assign nblack     = count_black(m);

    // innermost black sensor sets the turn level
    always_comb
    begin
        priority if (|(m & MASK_CENTER)) follow_level = 3'sd0;
        else if (m[2])                   follow_level = -3'sd1;
        else if (m[5])                   follow_level = 3'sd1;
        else if (m[1])                   follow_level = -3'sd2;
        else if (m[6])                   follow_level = 3'sd2;
        else if (m[0])                   follow_level = -3'sd3;
        else                             follow_level = 3'sd3;
    end

    // steering from a turn level
    assign steer_level = (state.mode == MODE_FOLLOW) ? follow_level : state.turn_level;

    always_comb
    begin
        steer_cmd   = (steer_level < 0) ? CMD_LEFT : CMD_RIGHT;
        steer_speed = SPIN_SPEED_3;
        unique case (steer_level)
            3'sd0:
            begin
                steer_cmd   = CMD_FORWARD;
                steer_speed = cfg.base_speed;
            end
            3'sd1, -3'sd1: steer_speed = SPIN_SPEED_1;
            3'sd2, -3'sd2: steer_speed = SPIN_SPEED_2;
            default:       steer_speed = SPIN_SPEED_3;
        endcase
    end

    // junction classification from the saved sides
    assign sl = state.saved_sides[0];
    assign sc = state.saved_sides[1];
    assign sr = state.saved_sides[2];

    always_comb
    begin
        kind = JK_NONE;
        if (m == 8'd0)
        begin
            if (sl && !sr)      kind = JK_LEFT;
            else if (!sl && sr) kind = JK_RIGHT;
        end
        else
        begin
            if (sl && sc && !sr)      kind = JK_T_LEFT;
            else if (!sl && sc && sr) kind = JK_T_RIGHT;
        end
    end

    // mode sequencing
    always_comb
    begin
        state_next = state;
        cmd        = CMD_NONE;
        spd        = 8'd0;
        unique case (state.mode)
            MODE_FOLLOW:
            begin
                priority if (m == MASK_ALL)
                begin
                    cmd                       = CMD_FORWARD;
                    spd                       = cfg.base_speed;
                    state_next.junction_store = JK_T_FORWARD;
                end
                else if (nblack >= 4'd3)
                begin
                    state_next.saved_sides   = sides_of(m);
                    state_next.mode          = MODE_POTENTIAL;
                    state_next.mode_start_ms = item.now_ms;
                end
                else if (m == 8'd0)
                begin
                    if (!state.lost_since_valid)
                    begin
                        state_next.lost_since_ms    = item.now_ms;
                        state_next.lost_since_valid = 1'b1;
                    end
                    state_next.mode = MODE_LOST;
                end
                else
                begin
                    state_next.turn_level = follow_level;
                    cmd                   = steer_cmd;
                    spd                   = steer_speed;
                end
            end
            MODE_POTENTIAL:
            begin
                if (since_mode < cfg.junction_delay_ms)
                begin
                    cmd = CMD_FORWARD;
                    spd = cfg.base_speed;
                end
                else
                begin
                    cmd                      = CMD_STOP;
                    state_next.mode          = MODE_CONFIRM;
                    state_next.mode_start_ms = item.now_ms;
                    state_next.saved_sides   = sides_of(m);
                end
            end
            MODE_CONFIRM:
            begin
                if (since_mode >= {16'd0, cfg.settle_ms})
                begin
                    state_next.junction_store = kind;
                    state_next.mode           = MODE_FOLLOW;
                end
            end
            default:
            begin
                priority if (m != 8'd0)
                begin
                    state_next.mode             = MODE_FOLLOW;
                    state_next.lost_since_valid = 1'b0;
                    state_next.lost_since_ms    = 32'd0;
                end
                else if (since_lost > cfg.lost_timeout_ms)
                begin
                    cmd = CMD_STOP;
                end
                else
                begin
                    cmd = steer_cmd;
                    spd = steer_speed;
                end
            end
        endcase
    end

    // result beat
    assign res.motion_cmd    = cmd;
    assign res.drive_speed   = spd;
    assign res.junction_kind = state_next.junction_store;
    assign res.at_junction   = (state_next.junction_store != JK_NONE);
    assign res.mode_now      = state_next.mode;

endmodule

// ===== src/line_follower_junction_controller_unit.sv =====
// top level: input register, controller state, result register and config port
// Eight-sensor line follower controller with junction detection. One sensor beat
// (black mask and millisecond timestamp) gives one result beat (motion command,
// speed, stored junction kind and mode). A new beat is taken every clock while item_stall is
// low. A beat is held in the input register; the controller state and the result register
// update from it together when the result register is free, and the result is presented.
// item_stall rises only while the result register is full and stalled. Configuration
// writes are always ready and should be made while idle.
module line_follower_junction_controller_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  lfjc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output lfjc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata
);
    import lfjc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    lfjc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lfjc_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (result_next)
    );

    // pipeline moves when the result register is free
    assign advance    = !(result_valid_reg && result_stall);
    assign item_stall = item_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (advance || !item_valid_reg)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= MODE_FOLLOW;
            state_reg.mode_start_ms    <= 32'd0;
            state_reg.lost_since_ms    <= 32'd0;
            state_reg.lost_since_valid <= 1'b0;
            state_reg.turn_level       <= 3'sd0;
            state_reg.junction_store   <= JK_NONE;
            state_reg.saved_sides      <= 3'd0;
        end
        else if (item_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid_reg && advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // line lost always carries a loss start time
    a_lost_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode == MODE_LOST |-> state_reg.lost_since_valid)
        else $error("line lost mode without loss start time");

    // emergency stop never drives
    a_stop_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.motion_cmd == CMD_STOP |->
            result_reg.drive_speed == 8'd0)
        else $error("emergency stop with nonzero speed");

    // while confirming the car is stopped or idle
    a_confirm_still: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.mode_now == MODE_CONFIRM |->
            result_reg.motion_cmd == CMD_STOP || result_reg.motion_cmd == CMD_NONE)
        else $error("motion while confirming a junction");

    // a stalled input beat is only ever held in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> item_valid_reg)
        else $error("input register emptied during stall");
`endif

endmodule

// ===== tb/line_follower_junction_controller_unit_tb.sv =====
// self-checking testbench for the line follower junction controller
module line_follower_junction_controller_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfjc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 165;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic    cfg_valid    = 1'b0;
    logic    cfg_ready;
    logic [1:0]  cfg_index = REG_BASE_SPEED;
    logic [31:0] cfg_wdata = 32'd0;

    // stimulus and scoreboard storage
    item_t   pending_beats[$];
    result_t predicted_results[$];
    int      beats_queued   = 0;
    int      results_seen   = 0;
    int      mismatches     = 0;
    int      junctions_done = 0;
    int      estops_seen    = 0;
    int      cycles         = 0;
    int      gap_left       = 0;
    int      stall_left     = 0;
    bit      send_quiet     = 1'b0;
    bit      recv_quiet     = 1'b0;
    logic [31:0] stim_ms    = 32'd0;
    int      step_max       = 4;

    // predictor copy of the registers and controller state
    cfg_t settings = {BASE_SPEED_RST, LOST_TIMEOUT_RST, JUNC_DELAY_RST, SETTLE_RST};
    logic [1:0]        ctl_mode         = MODE_FOLLOW;
    logic [31:0]       phase_start_ms   = 32'd0;
    logic [31:0]       lost_start_ms    = 32'd0;
    logic              lost_start_valid = 1'b0;
    logic signed [2:0] steer_level      = 3'sd0;
    logic [2:0]        held_junction    = JK_NONE;
    logic [2:0]        sides_seen       = 3'd0;

    line_follower_junction_controller_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // left, center, right groups seen black
    function automatic logic [2:0] occupied_sides(input logic [7:0] m);
        return {m[7] | m[6], m[4] | m[3], m[1] | m[0]};
    endfunction

    // steering output from the remembered turn level
    function automatic void steer_drive(output logic [2:0] cmd, output logic [7:0] spd);
        int mag;
        mag = (steer_level < 0) ? -int'(steer_level) : int'(steer_level);
        if (mag == 0)
        begin
            cmd = CMD_FORWARD;
            spd = settings.base_speed;
        end
        else
        begin
            cmd = (steer_level > 0) ? CMD_RIGHT : CMD_LEFT;
            spd = 8'(mag * 25);
        end
    endfunction

    // next controller state and the result beat for one sensor beat
    function automatic result_t advance_controller(input item_t beat);
        logic [7:0]  m;
        logic [31:0] elapsed;
        logic [2:0]  cmd;
        logic [7:0]  spd;
        logic        l;
        logic        c;
        logic        r;
        result_t     res;
        m   = beat.black_mask;
        cmd = CMD_NONE;
        spd = 8'd0;
        case (ctl_mode)
            MODE_FOLLOW:
            begin
                if (m == MASK_ALL)
                begin
                    cmd = CMD_FORWARD;
                    spd = settings.base_speed;
                    held_junction = JK_T_FORWARD;
                end
                else if ($countones(m) >= 3)
                begin
                    sides_seen     = occupied_sides(m);
                    ctl_mode       = MODE_POTENTIAL;
                    phase_start_ms = beat.now_ms;
                end
                else if (m == 8'd0)
                begin
                    if (!lost_start_valid)
                    begin
                        lost_start_ms    = beat.now_ms;
                        lost_start_valid = 1'b1;
                    end
                    ctl_mode = MODE_LOST;
                end
                else
                begin
                    // innermost black sensor wins
                    if ((m & MASK_CENTER) != 8'd0) steer_level = 3'sd0;
                    else if (m[2]) steer_level = -3'sd1;
                    else if (m[5]) steer_level = 3'sd1;
                    else if (m[1]) steer_level = -3'sd2;
                    else if (m[6]) steer_level = 3'sd2;
                    else if (m[0]) steer_level = -3'sd3;
                    else steer_level = 3'sd3;
                    steer_drive(cmd, spd);
                end
            end
            MODE_POTENTIAL:
            begin
                elapsed = beat.now_ms - phase_start_ms;
                if (elapsed < settings.junction_delay_ms)
                begin
                    cmd = CMD_FORWARD;
                    spd = settings.base_speed;
                end
                else
                begin
                    cmd            = CMD_STOP;
                    ctl_mode       = MODE_CONFIRM;
                    phase_start_ms = beat.now_ms;
                    sides_seen     = occupied_sides(m);
                end
            end
            MODE_CONFIRM:
            begin
                elapsed = beat.now_ms - phase_start_ms;
                if (elapsed >= {16'd0, settings.settle_ms})
                begin
                    l = sides_seen[0];
                    c = sides_seen[1];
                    r = sides_seen[2];
                    held_junction = JK_NONE;
                    if (m == 8'd0)
                    begin
                        if (l && !r) held_junction = JK_LEFT;
                        else if (!l && r) held_junction = JK_RIGHT;
                    end
                    else
                    begin
                        if (l && c && !r) held_junction = JK_T_LEFT;
                        else if (!l && c && r) held_junction = JK_T_RIGHT;
                    end
                    if (held_junction != JK_NONE) junctions_done++;
                    ctl_mode = MODE_FOLLOW;
                end
            end
            default:
            begin
                elapsed = beat.now_ms - lost_start_ms;
                if (m != 8'd0)
                begin
                    ctl_mode         = MODE_FOLLOW;
                    lost_start_valid = 1'b0;
                    lost_start_ms    = 32'd0;
                end
                else if (elapsed > settings.lost_timeout_ms)
                begin
                    cmd = CMD_STOP;
                    estops_seen++;
                end
                else
                begin
                    steer_drive(cmd, spd);
                end
            end
        endcase
        res.motion_cmd    = cmd;
        res.drive_speed   = spd;
        res.junction_kind = held_junction;
        res.at_junction   = (held_junction != JK_NONE);
        res.mode_now      = ctl_mode;
        return res;
    endfunction

    // sensor beat driver with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left    = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predicted_results.push_back(advance_controller(item));
            if (!item_valid || !item_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    item       <= pending_beats.pop_front();
                    item_valid <= 1'b1;
                    gap_left    = send_quiet ? 0 : $urandom_range(0, 7);
                    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result beat: expected none, got %p", $time, result);
                end
                else if (predicted_results[0] !== result)
                begin
                    mismatches++;
                    $display("%0t mismatch: expected %p, got %p",
                             $time, predicted_results[0], result);
                    void'(predicted_results.pop_front());
                end
                else
                begin
                    void'(predicted_results.pop_front());
                end
                stall_left = recv_quiet ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
            end
            result_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time,
                     beats_queued - results_seen);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_beat(input logic [7:0] m, input logic [31:0] t);
        item_t beat;
        beat.black_mask = m;
        beat.now_ms     = t;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    // advance the clock of the stimulus and queue a beat
    task automatic next_beat(input logic [7:0] m);
        if ($urandom_range(0, 99) < 3) stim_ms = $urandom();
        else stim_ms = stim_ms + 32'($urandom_range(0, step_max));
        push_beat(m, stim_ms);
    endtask

    function automatic logic [7:0] line_mask();
        int pos;
        logic [7:0] m;
        pos = $urandom_range(0, 7);
        m   = 8'd1 << pos;
        if (pos < 7 && $urandom_range(0, 1) == 1) m = m | (8'd1 << (pos + 1));
        return m;
    endfunction

    function automatic logic [7:0] junction_mask();
        logic [7:0] m;
        case ($urandom_range(0, 4))
            0: m = 8'h1F;
            1: m = 8'hF8;
            2: m = 8'h07;
            3: m = 8'hE0;
            default: m = 8'($urandom());
        endcase
        m = m | 8'($urandom() & $urandom() & $urandom());
        while ($countones(m) < 3) m = m | (8'd1 << $urandom_range(0, 7));
        return m;
    endfunction

    function automatic logic [7:0] any_mask();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return 8'd0;
        if (pick < 60) return line_mask();
        if (pick < 90) return junction_mask();
        if (pick < 95) return MASK_ALL;
        return 8'($urandom());
    endfunction

    // traffic shaped as follow, junction, lost and noise stretches
    task automatic random_traffic(input int count);
        int first;
        first = beats_queued;
        while (beats_queued - first < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    repeat ($urandom_range(2, 10)) next_beat(line_mask());
                end
                4, 5, 6:
                begin
                    next_beat(junction_mask());
                    repeat ($urandom_range(0, 8)) next_beat(any_mask());
                    repeat ($urandom_range(1, 3)) next_beat(any_mask());
                end
                7, 8:
                begin
                    repeat ($urandom_range(1, 12)) next_beat(8'd0);
                    next_beat(line_mask());
                end
                default:
                begin
                    repeat ($urandom_range(1, 4)) next_beat(8'($urandom()));
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        while (results_seen != beats_queued) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_BASE_SPEED, {24'd0, c.base_speed});
        write_reg(REG_LOST_TIMEOUT, c.lost_timeout_ms);
        write_reg(REG_JUNC_DELAY, c.junction_delay_ms);
        write_reg(REG_SETTLE, {16'd0, c.settle_ms});
        cfg_valid <= 1'b0;
        settings = c;
    endtask

    // reset, directed beats, then randomized phases
    initial
    begin
        cfg_t c;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // steering by each sensor position
        push_beat(8'h01, 32'd0);
        push_beat(8'h02, 32'd1);
        push_beat(8'h04, 32'd2);
        push_beat(8'h08, 32'd3);
        push_beat(8'h10, 32'd4);
        push_beat(8'h20, 32'd5);
        push_beat(8'h40, 32'd6);
        push_beat(8'h80, 32'd7);
        // line lost, spin while lost, timeout boundary, recovery
        push_beat(8'h00, 32'd10);
        push_beat(8'h00, 32'd500);
        push_beat(8'h00, 32'd2010);
        push_beat(8'h00, 32'd2011);
        push_beat(8'h18, 32'd2020);
        // all black while following
        push_beat(8'hFF, 32'd2100);
        // T left junction
        push_beat(8'h1F, 32'd3000);
        push_beat(8'h18, 32'd3500);
        push_beat(8'h1F, 32'd4000);
        push_beat(8'h18, 32'd4100);
        push_beat(8'h18, 32'd4200);
        // left turn ending all white
        push_beat(8'h07, 32'd5000);
        push_beat(8'h03, 32'd6000);
        push_beat(8'h00, 32'd6200);
        // T right across the timestamp wrap
        push_beat(8'hF8, 32'hFFFF_FF00);
        push_beat(8'hF8, 32'h0000_02E8);
        push_beat(8'h18, 32'h0000_03B0);
        wait_idle();

        stim_ms = 32'h0000_0400;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    c.base_speed        = 8'd0;
                    c.lost_timeout_ms   = 32'd0;
                    c.junction_delay_ms = 32'd0;
                    c.settle_ms         = 16'd0;
                end
                1:
                begin
                    c.base_speed        = 8'hFF;
                    c.lost_timeout_ms   = 32'hFFFF_FFFF;
                    c.junction_delay_ms = 32'hFFFF_FFFF;
                    c.settle_ms         = 16'hFFFF;
                end
                PHASES - 1:
                begin
                    c.base_speed        = 8'($urandom());
                    c.lost_timeout_ms   = $urandom();
                    c.junction_delay_ms = $urandom();
                    c.settle_ms         = 16'($urandom());
                end
                default:
                begin
                    c.base_speed        = 8'($urandom_range(0, 255));
                    c.lost_timeout_ms   = 32'($urandom_range(0, 40));
                    c.junction_delay_ms = 32'($urandom_range(0, 30));
                    c.settle_ms         = 16'($urandom_range(0, 20));
                end
            endcase
            apply_settings(c);
            step_max = (p == 0) ? 3 : $urandom_range(1, 8);
            if (p == 3) stim_ms = 32'hFFFF_FF80;
            random_traffic(PHASE_BEATS);
            // sender holds off until every result of the phase is back
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            mismatches += predicted_results.size();
            $display("%0t %0d expected results never arrived", $time, predicted_results.size());
        end
        $display("ran %0d sensor beats through %0d register settings", beats_queued, PHASES + 1);
        $display("%0d junctions classified, %0d emergency stops, %0d mismatches",
                 junctions_done, estops_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
